>>> hdl/plip_pkg.sv
// package for the prefixed integer literal parser
// types, codes and constants shared by plip_accum and the top level; no dependencies
package plip_pkg;

    // longest string length counted before the length saturates
    localparam int C_MAX_LENGTH = 65535;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // characters with a special meaning
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_OCT   = 8'h4F;
    localparam logic [7:0] CH_HEX   = 8'h48;

    // number base
    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    // input transaction: one character of the string
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_in_item;

    // output transaction: one parsed literal
    typedef struct packed {
        logic signed [63:0] value;
        logic [15:0]        consumed_length;
        logic [1:0]         status;
    } t_out_item;

    // accumulator result for one character
    typedef struct packed {
        logic        is_digit;
        logic [63:0] mag;
        logic [63:0] neg;
        logic        ovf;
    } t_acc;

endpackage

>>> hdl/plip_accum.sv
// digit decode and shift-add accumulator step of the literal parser
// depends on plip_pkg
module plip_accum (
    input  logic [7:0]      i_char,
    input  plip_pkg::t_base i_base,
    input  logic [63:0]     i_mag,
    input  logic [63:0]     i_neg,
    input  logic            i_ovf,
    output plip_pkg::t_acc  o_acc
);
    import plip_pkg::*;

    logic [3:0]  digit;
    logic        is_digit;
    logic [67:0] mag_ext;
    logic [67:0] sum;
    logic [63:0] neg_sum;
    logic        over;

    // digit decode in the current base
    always_comb begin
        digit    = '0;
        is_digit = 1'b0;
        case (i_base)
            BASE_OCT: begin
                if (i_char inside {[8'h30:8'h37]}) begin
                    is_digit = 1'b1;
                    digit    = i_char[3:0];
                end
            end
            BASE_HEX: begin
                if (i_char inside {[8'h30:8'h39]}) begin
                    is_digit = 1'b1;
                    digit    = i_char[3:0];
                end else if (i_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
                    is_digit = 1'b1;
                    digit    = i_char[3:0] + 4'd9;
                end
            end
            default: begin
                if (i_char inside {[8'h30:8'h39]}) begin
                    is_digit = 1'b1;
                    digit    = i_char[3:0];
                end
            end
        endcase
    end

    // magnitude times radix plus digit, and the negated value kept alongside
    always_comb begin
        mag_ext = {4'b0, i_mag};
        case (i_base)
            BASE_OCT: begin
                sum     = (mag_ext << 3) + {64'b0, digit};
                neg_sum = (i_neg << 3) - {60'b0, digit};
            end
            BASE_HEX: begin
                sum     = (mag_ext << 4) + {64'b0, digit};
                neg_sum = (i_neg << 4) - {60'b0, digit};
            end
            default: begin
                sum     = (mag_ext << 3) + (mag_ext << 1) + {64'b0, digit};
                neg_sum = (i_neg << 3) + (i_neg << 1) - {60'b0, digit};
            end
        endcase
        // magnitude must stay at or below 2^63
        over = (sum > {4'b0, 1'b1, 63'b0});
    end

    // once out of range the magnitude is frozen
    always_comb begin
        o_acc.is_digit = is_digit;
        o_acc.ovf      = i_ovf | (is_digit & over);
        if (i_ovf || over || !is_digit) begin
            o_acc.mag = i_mag;
            o_acc.neg = i_neg;
        end else begin
            o_acc.mag = sum[63:0];
            o_acc.neg = neg_sum;
        end
    end

endmodule

>>> hdl/prefixed_integer_literal_parser.sv
// top level of the prefixed integer literal parser
// depends on plip_pkg and plip_accum
//
//  channel | signals                              | payload
//  --------+--------------------------------------+-------------------------
//  in      | i_in_valid, o_in_stall, i_in_data    | character, last_char
//  out     | o_out_valid, i_out_stall, o_out_data | value, length, status
//
// one character per cycle unless stalled; a result passes r_in and then r_out
// unless stalled, the character register feeds one 64-bit shift-add per cycle
// i_rst_n is synchronous and returns the parser to the start of a string
// a stall on out holds the result register and backs up into the character register
module prefixed_integer_literal_parser #(
    parameter int P_MAX_LENGTH = plip_pkg::C_MAX_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  plip_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output plip_pkg::t_out_item o_out_data
);
    import plip_pkg::*;

    localparam logic [15:0] L_MAX_POS = 16'(P_MAX_LENGTH);

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_AMP,
        PH_NEED,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    logic        r_in_valid;
    t_in_item    r_in;
    t_phase      r_phase, n_phase;
    logic        r_negf, n_negf;
    t_base       r_base, n_base;
    logic [63:0] r_mag, n_mag;
    logic [63:0] r_neg, n_neg;
    logic [15:0] r_pos, n_pos;
    logic        r_ovf, n_ovf;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    logic        advance;
    logic        emit;
    logic        emit_val;
    logic        bad;
    logic [15:0] pos_bump;
    t_acc        acc;

    // accept a transaction unless the held character cannot move on
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign pos_bump   = (r_pos != L_MAX_POS) ? r_pos + 16'd1 : r_pos;

    plip_accum u_accum (
        .i_char (r_in.character),
        .i_base (r_base),
        .i_mag  (r_mag),
        .i_neg  (r_neg),
        .i_ovf  (r_ovf),
        .o_acc  (acc)
    );

    // parse step for the held character
    always_comb begin
        n_phase  = r_phase;
        n_negf   = r_negf;
        n_base   = r_base;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        emit     = 1'b0;
        emit_val = 1'b0;
        case (r_phase)
            PH_START, PH_SIGNED: begin
                if (r_phase == PH_START && r_in.character == CH_MINUS) begin
                    n_negf  = 1'b1;
                    n_pos   = pos_bump;
                    n_phase = PH_SIGNED;
                    emit    = r_in.last_char;
                end else if (r_in.character == CH_AMP) begin
                    n_pos   = pos_bump;
                    n_phase = PH_AMP;
                    emit    = r_in.last_char;
                end else begin
                    n_base = BASE_DEC;
                    if (acc.is_digit) begin
                        n_pos    = pos_bump;
                        n_mag    = acc.mag;
                        n_neg    = acc.neg;
                        n_ovf    = acc.ovf;
                        n_phase  = PH_DIGITS;
                        emit     = r_in.last_char;
                        emit_val = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_AMP: begin
                if (r_in.character == CH_OCT || r_in.character == CH_HEX) begin
                    n_base  = (r_in.character == CH_OCT) ? BASE_OCT : BASE_HEX;
                    n_pos   = pos_bump;
                    n_phase = PH_NEED;
                    emit    = r_in.last_char;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_DONE;
                end
            end
            PH_NEED, PH_DIGITS: begin
                if (acc.is_digit) begin
                    n_pos    = pos_bump;
                    n_mag    = acc.mag;
                    n_neg    = acc.neg;
                    n_ovf    = acc.ovf;
                    n_phase  = PH_DIGITS;
                    emit     = r_in.last_char;
                    emit_val = 1'b1;
                end else begin
                    emit     = 1'b1;
                    emit_val = (r_phase == PH_DIGITS);
                    n_phase  = PH_DONE;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // result fields
        bad = n_ovf || (!r_negf && n_mag[63]);
        if (!emit_val) begin
            n_out.value           = '0;
            n_out.consumed_length = '0;
            n_out.status          = ST_NO_DIGITS;
        end else if (bad) begin
            n_out.value           = '0;
            n_out.consumed_length = n_pos;
            n_out.status          = ST_RANGE;
        end else begin
            n_out.value           = r_negf ? n_neg : n_mag;
            n_out.consumed_length = n_pos;
            n_out.status          = ST_OK;
        end

        // end of string: back to the start state
        if (r_in.last_char) begin
            n_phase = PH_START;
            n_negf  = 1'b0;
            n_base  = BASE_DEC;
            n_mag   = '0;
            n_neg   = '0;
            n_pos   = '0;
            n_ovf   = 1'b0;
        end
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_START;
            r_negf      <= 1'b0;
            r_base      <= BASE_DEC;
            r_mag       <= '0;
            r_neg       <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= advance && emit;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_negf  <= n_negf;
                r_base  <= n_base;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_pos   <= n_pos;
                r_ovf   <= n_ovf;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_NO_DIGITS
        |-> r_out.value == '0 && r_out.consumed_length == '0)
        else $error("no-digit result carries a value or length");

    a_range_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_RANGE |-> r_out.value == '0)
        else $error("out-of-range result carries a value");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= L_MAX_POS)
        else $error("position passed the length limit");

    a_held_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held character lost while the result side was stalled");

endmodule

>>> test/tb.sv
// testbench for the prefixed integer literal parser: streams strings one character at a time
// and checks every parsed literal against a predictor held in the testbench; depends on plip_pkg
`timescale 1ns / 100ps

module tb;

    import plip_pkg::*;

    localparam int MAX_WAIT     = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_CHARS = 500;
    localparam int LONG_ZEROS   = 300;

    // where the predictor stands within the current string
    typedef enum logic [2:0] {
        LP_START,
        LP_AFTER_SIGN,
        LP_AFTER_AMP,
        LP_NEED_DIGIT,
        LP_IN_DIGITS,
        LP_SKIP
    } t_lit_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // predictor state
    t_lit_phase  lit_phase;
    bit          lit_negative;
    t_base       lit_base;
    logic [63:0] lit_magnitude;
    int          lit_position;
    bit          lit_overflow;
    t_out_item   pending_literals[$];

    // string being built for the sender
    logic [7:0] literal_text[$];

    // run control and counters
    bit idle_in;
    bit idle_out;
    int hold_left;
    int stall_left;
    int cycle_count;
    int chars_sent;
    int strings_sent;
    int literals_checked;
    int n_mismatches;

    prefixed_integer_literal_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // value of a character as a digit of the base, -1 when it is not one
    function automatic int base_digit(logic [7:0] c, t_base b);
        case (b)
            BASE_OCT: begin
                return (c >= "0" && c <= "7") ? int'(c - "0") : -1;
            end
            BASE_HEX: begin
                if (c >= "0" && c <= "9") return int'(c - "0");
                if (c >= "A" && c <= "F") return int'(c - "A") + 10;
                if (c >= "a" && c <= "f") return int'(c - "a") + 10;
                return -1;
            end
            default: begin
                return (c >= "0" && c <= "9") ? int'(c - "0") : -1;
            end
        endcase
    endfunction

    function automatic void reset_literal();
        lit_phase     = LP_START;
        lit_negative  = 1'b0;
        lit_base      = BASE_DEC;
        lit_magnitude = '0;
        lit_position  = 0;
        lit_overflow  = 1'b0;
    endfunction

    // length saturates but digits keep accumulating
    function automatic void count_char();
        if (lit_position < C_MAX_LENGTH) lit_position++;
    endfunction

    // multiply-add with sticky overflow past 2^63
    function automatic void add_digit(int d);
        logic [63:0] radix;
        radix = (lit_base == BASE_OCT) ? 64'd8 : (lit_base == BASE_HEX) ? 64'd16 : 64'd10;
        if (lit_overflow) return;
        if (lit_magnitude > (64'h8000_0000_0000_0000 - 64'(d)) / radix) begin
            lit_overflow = 1'b1;
        end else begin
            lit_magnitude = lit_magnitude * radix + 64'(d);
        end
    endfunction

    // expected literal goes to the back of the queue
    function automatic void queue_literal(t_out_item r);
        pending_literals.insert(pending_literals.size(), r);
    endfunction

    function automatic void expect_no_digits();
        t_out_item r;
        r.value           = '0;
        r.consumed_length = '0;
        r.status          = ST_NO_DIGITS;
        queue_literal(r);
    endfunction

    function automatic void expect_value();
        t_out_item r;
        if (lit_overflow || (!lit_negative && lit_magnitude > 64'h7FFF_FFFF_FFFF_FFFF)) begin
            r.value  = '0;
            r.status = ST_RANGE;
        end else begin
            r.value  = lit_negative ? 64'd0 - lit_magnitude : lit_magnitude;
            r.status = ST_OK;
        end
        r.consumed_length = lit_position[15:0];
        queue_literal(r);
    endfunction

    // advance the predictor by one accepted character
    function automatic void parse_char(logic [7:0] c, logic last);
        int d;
        case (lit_phase)
            LP_START, LP_AFTER_SIGN: begin
                if (lit_phase == LP_START && c == CH_MINUS) begin
                    lit_negative = 1'b1;
                    count_char();
                    lit_phase = LP_AFTER_SIGN;
                    if (last) expect_no_digits();
                end else if (c == CH_AMP) begin
                    count_char();
                    lit_phase = LP_AFTER_AMP;
                    if (last) expect_no_digits();
                end else begin
                    lit_base = BASE_DEC;
                    d = base_digit(c, BASE_DEC);
                    if (d >= 0) begin
                        count_char();
                        add_digit(d);
                        lit_phase = LP_IN_DIGITS;
                        if (last) expect_value();
                    end else begin
                        expect_no_digits();
                        lit_phase = LP_SKIP;
                    end
                end
            end
            LP_AFTER_AMP: begin
                if (c == CH_OCT || c == CH_HEX) begin
                    lit_base = (c == CH_OCT) ? BASE_OCT : BASE_HEX;
                    count_char();
                    lit_phase = LP_NEED_DIGIT;
                    if (last) expect_no_digits();
                end else begin
                    expect_no_digits();
                    lit_phase = LP_SKIP;
                end
            end
            LP_NEED_DIGIT, LP_IN_DIGITS: begin
                d = base_digit(c, lit_base);
                if (d >= 0) begin
                    count_char();
                    add_digit(d);
                    lit_phase = LP_IN_DIGITS;
                    if (last) expect_value();
                end else begin
                    if (lit_phase == LP_IN_DIGITS) expect_value();
                    else expect_no_digits();
                    lit_phase = LP_SKIP;
                end
            end
            default: ;
        endcase
        if (last) reset_literal();
    endfunction

    // ---------------------------------------------------------------- string building

    // one character onto the end of the string
    function automatic void append_char(logic [7:0] c);
        literal_text.insert(literal_text.size(), c);
    endfunction

    function automatic void add_text(string txt);
        for (int i = 0; i < txt.len(); i++) append_char(txt[i]);
    endfunction

    function automatic void add_prefix(t_base b);
        if (b == BASE_OCT) add_text("&O");
        else if (b == BASE_HEX) add_text("&H");
    endfunction

    // hex letters come in either case
    function automatic logic [7:0] digit_char(int d);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    function automatic void add_number(logic [63:0] mag, t_base b);
        logic [63:0] radix;
        logic [7:0]  rev[$];
        radix = (b == BASE_OCT) ? 64'd8 : (b == BASE_HEX) ? 64'd16 : 64'd10;
        if (mag == 0) rev.push_front("0");
        while (mag != 0) begin
            rev.push_front(digit_char(int'(mag % radix)));
            mag = mag / radix;
        end
        foreach (rev[i]) append_char(rev[i]);
    endfunction

    function automatic void add_random_digits(t_base b, int n);
        int radix;
        radix = (b == BASE_OCT) ? 8 : (b == BASE_HEX) ? 16 : 10;
        repeat (n) append_char(digit_char($urandom_range(0, radix - 1)));
    endfunction

    // ---------------------------------------------------------------- sender

    // one input transaction; valid stays high afterwards for back-to-back items
    task automatic drive_char(logic [7:0] c, logic last);
        int gap;
        gap = idle_in ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{character: c, last_char: last};
        do @(posedge i_clk); while (o_in_stall);
        parse_char(c, last);
        chars_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < literal_text.size(); i++) begin
            drive_char(literal_text[i], i == literal_text.size() - 1);
        end
        literal_text.delete();
        strings_sent++;
    endtask

    task automatic send_text(string txt);
        add_text(txt);
        send_literal();
    endtask

    // sender goes quiet until every expected literal has come out
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_literals.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver and checker

    // stall per result, plus the long hold when one is requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic check_literal(t_out_item got);
        t_out_item want;
        if (pending_literals.size() == 0) begin
            n_mismatches++;
            if (n_mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected literal value=%0d length=%0d status=%0d",
                         $realtime, got.value, got.consumed_length, got.status);
        end else begin
            want = pending_literals.pop_front();
            literals_checked++;
            if (got.value !== want.value || got.consumed_length !== want.consumed_length ||
                    got.status !== want.status) begin
                n_mismatches++;
                if (n_mismatches <= REPORT_LIMIT)
                    $display("%0t: literal mismatch value %0d/%0d length %0d/%0d status %0d/%0d",
                             $realtime, want.value, got.value, want.consumed_length,
                             got.consumed_length, want.status, got.status);
            end
        end
    endtask

    // result sampling and watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d literals outstanding",
                     cycle_count, pending_literals.size());
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_literal(o_out_data);
            stall_left = idle_out ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    // ---------------------------------------------------------------- tests

    // sign and prefix corner cases, every base, terminators and ignored tails
    task automatic test_special_cases();
        send_text("-");
        send_text("&");
        send_text("&O");
        send_text("&H");
        send_text("&x");
        send_text("&h1");
        send_text("--5");
        send_text("&O8");
        send_text("abc");
        send_text("0");
        send_text("12x3");
        send_text("-&O17");
        send_text("&HfF;z");
    endtask

    // both ends of the signed 64-bit range and one past them
    task automatic test_range_limits();
        send_text("9223372036854775807");
        send_text("9223372036854775808");
        send_text("-9223372036854775808");
        send_text("-9223372036854775809");
        send_text("-&H8000000000000000");
        send_text("&HFFFFFFFFFFFFFFFF");
        send_text("&O777777777777777777777");
    endtask

    // receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        idle_in   = 1'b0;
        hold_left = 300;
        repeat (40) begin
            append_char(digit_char($urandom_range(0, 9)));
            send_literal();
        end
    endtask

    // long run of leading zeros, length counted and digits still accumulated
    task automatic test_long_string();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        add_text("-&H");
        repeat (LONG_ZEROS) append_char("0");
        add_text("1f");
        send_literal();
    endtask

    // mostly well-formed literals with random content, some broken ones and noise
    task automatic test_random();
        int          start;
        int          n;
        int          kind;
        bit          neg;
        t_base       base;
        logic [63:0] mag;
        start = chars_sent;
        n     = 0;
        while (chars_sent - start < RANDOM_CHARS) begin
            if (n % 20 == 0) begin
                idle_in  = $urandom_range(0, 3) != 0;
                idle_out = $urandom_range(0, 3) != 0;
            end
            if (n % 50 == 49) pause_until_drained();
            kind = $urandom_range(0, 99);
            neg  = 1'($urandom_range(0, 1));
            base = t_base'($urandom_range(0, 2));
            if (kind < 60) begin
                // well-formed, sometimes long enough to overflow
                if (neg) add_text("-");
                add_prefix(base);
                if ($urandom_range(0, 4) == 0)
                    add_random_digits(base, $urandom_range(12, (base == BASE_OCT) ? 23 :
                                                                (base == BASE_HEX) ? 17 : 20));
                else
                    add_random_digits(base, $urandom_range(1, 8));
                if ($urandom_range(0, 9) < 4)
                    repeat ($urandom_range(1, 4))
                        append_char(8'($urandom_range(0, 255)));
            end else if (kind < 75) begin
                // magnitudes around the range limits
                if (neg) add_text("-");
                add_prefix(base);
                case ($urandom_range(0, 4))
                    0: mag = 64'h7FFF_FFFF_FFFF_FFFF;
                    1: mag = 64'h8000_0000_0000_0000;
                    2: mag = 64'h8000_0000_0000_0001;
                    3: mag = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
                add_number(mag, base);
                if ($urandom_range(0, 1)) append_char(8'($urandom_range(0, 255)));
            end else if (kind < 90) begin
                // broken sign or prefix
                case ($urandom_range(0, 3))
                    0: add_text("&");
                    1: add_text("-");
                    2: begin
                        if (neg) add_text("-");
                        add_prefix((base == BASE_DEC) ? BASE_OCT : base);
                    end
                    default: add_text($urandom_range(0, 1) ? "&o" : "&h");
                endcase
                repeat ($urandom_range(0, 2)) append_char(8'($urandom_range(0, 255)));
            end else begin
                // raw bytes
                repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
            end
            send_literal();
            n++;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        idle_in    = 1'b1;
        idle_out   = 1'b1;
        hold_left  = 0;
        stall_left = 0;
        reset_literal();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        pause_until_drained();
        test_range_limits();
        pause_until_drained();
        test_backpressure();
        pause_until_drained();
        test_long_string();
        pause_until_drained();
        test_random();
        pause_until_drained();
        repeat (8) @(posedge i_clk);

        $display("sent %0d characters in %0d strings, checked %0d literals, %0d mismatches",
                 chars_sent, strings_sent, literals_checked, n_mismatches);
        $display("covered all bases, sign and prefix errors, range limits, long digit runs"
                 , " and a long result-side hold");
        if (n_mismatches == 0 && pending_literals.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
